### hw/rtl/lsts_pkg.sv
`default_nettype none
package lsts_pkg;

    localparam int unsigned DIV1_STAGES = 48;  // bits of (hi << 16)
    localparam int unsigned DIV2_STAGES = 17;  // quotient bits of alpha
    localparam logic [16:0] Q_ONE       = 17'd65536;
    localparam logic [30:0] Q_ONE_RATIO = 31'd65536;
    localparam logic [31:0] MIN_SPEED   = 32'd66;

    typedef enum logic [1:0] {
        CFG_SPLIT  = 2'd0,
        CFG_ENABLE = 2'd1,
        CFG_RATIO  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
    } t_in_word;

    typedef struct packed {
        logic [16:0] left_share;
        logic [16:0] right_share;
    } t_out_word;

    typedef struct packed {
        logic [16:0] split;
        logic        enable;
        logic [30:0] ratio;
    } t_cfg;

    // travels down the pipe beside each word
    typedef struct packed {
        logic slower_left;
    } t_side;

endpackage
`default_nettype wire

### hw/rtl/limited_slip_torque_split.sv
`default_nettype none
// channel  | direction | handshake               | word
// input    | in        | i_in_valid / o_in_stall | i_in_data   (t_in_word)
// output   | out       | o_out_valid/ i_out_stall| o_out_data  (t_out_word)
// config   | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
// One word per cycle while the output is not stalled; input stage, 48-stage ratio divider,
// 18-stage alpha divider, 2 mix stages ending in the output register.
// The 48 one-bit steps of the speed-ratio divider set the depth.
// A stalled output word freezes the whole pipe; o_in_stall follows at once.
// Synchronous active-low reset clears valid bits and loads config defaults.
module limited_slip_torque_split
    import lsts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split  <= 17'd32768;
            r_cfg.enable <= 1'b1;
            r_cfg.ratio  <= 31'd91750;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SPLIT:  r_cfg.split  <= i_cfg_data[16:0];
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                CFG_RATIO:  r_cfg.ratio  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    logic        f_valid, d1_valid, d2_valid;
    logic [31:0] f_hi, f_lo;
    logic [40:0] d1_q;
    logic [16:0] d2_alpha;
    t_side       f_side, d1_side, d2_side;

    lsts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_in_valid), .i_word(i_in_data),
        .o_valid(f_valid), .o_hi(f_hi), .o_lo(f_lo), .o_side(f_side)
    );

    lsts_ratio_div u_ratio_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(f_valid), .i_hi(f_hi), .i_lo(f_lo), .i_side(f_side),
        .o_valid(d1_valid), .o_q(d1_q), .o_side(d1_side)
    );

    lsts_alpha_div u_alpha_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_cfg(r_cfg),
        .i_valid(d1_valid), .i_q(d1_q), .i_side(d1_side),
        .o_valid(d2_valid), .o_alpha(d2_alpha), .o_side(d2_side)
    );

    lsts_mix u_mix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_cfg(r_cfg),
        .i_valid(d2_valid), .i_alpha(d2_alpha), .i_side(d2_side),
        .o_valid(o_out_valid), .o_word(o_out_data)
    );

endmodule
`default_nettype wire

### hw/rtl/lsts_front.sv
`default_nettype none
module lsts_front
    import lsts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_in_word    i_word,
    output logic             o_valid,
    output logic [31:0]      o_hi,
    output logic [31:0]      o_lo,
    output t_side            o_side
);

    logic [31:0] wl, wr, ml, mr;
    logic        n_slower_left;

    always_comb begin
        ml = i_word.left_speed[31]  ? (~i_word.left_speed)  + 32'd1 : i_word.left_speed;
        mr = i_word.right_speed[31] ? (~i_word.right_speed) + 32'd1 : i_word.right_speed;
        wl = (ml < MIN_SPEED) ? MIN_SPEED : ml;
        wr = (mr < MIN_SPEED) ? MIN_SPEED : mr;
        n_slower_left = wl < wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hi               <= n_slower_left ? wr : wl;
            o_lo               <= n_slower_left ? wl : wr;
            o_side.slower_left <= n_slower_left;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lsts_ratio_div.sv
`default_nettype none
module lsts_ratio_div
    import lsts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_hi,
    input  wire logic [31:0] i_lo,
    input  wire t_side       i_side,
    output logic             o_valid,
    output logic [40:0]      o_q,
    output t_side            o_side
);

    // restoring divide of (hi << 16) by lo, one quotient bit per stage
    logic        r_v    [1:DIV1_STAGES];
    logic [31:0] r_rem  [1:DIV1_STAGES];
    logic [47:0] r_num  [1:DIV1_STAGES];
    logic [47:0] r_q    [1:DIV1_STAGES];
    logic [31:0] r_lo   [1:DIV1_STAGES];
    t_side       r_side [1:DIV1_STAGES];

    for (genvar s = 0; s < DIV1_STAGES; s++) begin : g_stage
        logic        c_v;
        logic [31:0] c_rem, c_lo;
        logic [47:0] c_num, c_q;
        t_side       c_side;
        logic [32:0] t, diff;
        logic        ge;

        if (s == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_num  = {i_hi, 16'd0};
            assign c_q    = '0;
            assign c_lo   = i_lo;
            assign c_side = i_side;
        end else begin : g_next
            assign c_v    = r_v[s];
            assign c_rem  = r_rem[s];
            assign c_num  = r_num[s];
            assign c_q    = r_q[s];
            assign c_lo   = r_lo[s];
            assign c_side = r_side[s];
        end

        always_comb begin
            t    = {c_rem, c_num[47]};
            diff = t - {1'b0, c_lo};
            ge   = t >= {1'b0, c_lo};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= ge ? diff[31:0] : t[31:0];
                r_num[s+1]  <= {c_num[46:0], 1'b0};
                r_q[s+1]    <= {c_q[46:0], ge};
                r_lo[s+1]   <= c_lo;
                r_side[s+1] <= c_side;
            end
        end
    end

    assign o_valid = r_v[DIV1_STAGES];
    assign o_q     = r_q[DIV1_STAGES][40:0];  // quotient stays below 2^41
    assign o_side  = r_side[DIV1_STAGES];

endmodule
`default_nettype wire

### hw/rtl/lsts_alpha_div.sv
`default_nettype none
module lsts_alpha_div
    import lsts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    input  wire logic [40:0] i_q,
    input  wire t_side       i_side,
    output logic             o_valid,
    output logic [16:0]      o_alpha,
    output t_side            o_side
);

    // setup stage: d = q - 1.0, saturate when quotient would reach 2^17
    logic [40:0] d;
    logic [30:0] den;
    logic        sat;

    always_comb begin
        d   = i_q - 41'd65536;
        den = (i_cfg.ratio > Q_ONE_RATIO) ? i_cfg.ratio - Q_ONE_RATIO : 31'd1;
        sat = d >= {9'd0, den, 1'b0};
    end

    logic        r_v    [0:DIV2_STAGES];
    logic [30:0] r_rem  [0:DIV2_STAGES];
    logic [16:0] r_num  [0:DIV2_STAGES];
    logic [16:0] r_q    [0:DIV2_STAGES];
    logic        r_sat  [0:DIV2_STAGES];
    t_side       r_side [0:DIV2_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= d[31:1];         // below den unless saturated
            r_num[0]  <= {d[0], 16'd0};
            r_q[0]    <= '0;
            r_sat[0]  <= sat;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < DIV2_STAGES; s++) begin : g_stage
        logic [31:0] t, diff;
        logic        ge;

        always_comb begin
            t    = {r_rem[s], r_num[s][16]};
            diff = t - {1'b0, den};
            ge   = t >= {1'b0, den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= ge ? diff[30:0] : t[30:0];
                r_num[s+1]  <= {r_num[s][15:0], 1'b0};
                r_q[s+1]    <= {r_q[s][15:0], ge};
                r_sat[s+1]  <= r_sat[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[DIV2_STAGES];
    assign o_alpha = (r_sat[DIV2_STAGES] || r_q[DIV2_STAGES] > Q_ONE) ? Q_ONE
                                                                     : r_q[DIV2_STAGES];
    assign o_side  = r_side[DIV2_STAGES];

endmodule
`default_nettype wire

### hw/rtl/lsts_mix.sv
`default_nettype none
module lsts_mix
    import lsts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    input  wire logic [16:0] i_alpha,
    input  wire t_side       i_side,
    output logic             o_valid,
    output t_out_word        o_word
);

    logic [16:0] split, left0, right0, oma;

    always_comb begin
        split  = (i_cfg.split > Q_ONE) ? Q_ONE : i_cfg.split;
        left0  = Q_ONE - split;
        right0 = split;
        oma    = Q_ONE - i_alpha;
    end

    logic        r_v1;
    logic [33:0] r_pl, r_pr;
    logic [16:0] r_alpha;
    t_side       r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl    <= left0 * oma;
            r_pr    <= right0 * oma;
            r_alpha <= i_alpha;
            r_side  <= i_side;
        end
    end

    t_out_word n_word;

    always_comb begin
        if (i_cfg.enable) begin
            n_word.left_share  = r_pl[32:16] + (r_side.slower_left ? r_alpha : 17'd0);
            n_word.right_share = r_pr[32:16] + (r_side.slower_left ? 17'd0 : r_alpha);
        end else begin
            n_word.left_share  = left0;
            n_word.right_share = right0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_word <= n_word;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/lsts_checker.sv
`default_nettype none
module lsts_checker
    import lsts_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output stalled");

    a_share_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_data.left_share}
                         + {1'b0, o_out_data.right_share}) <= 18'd65536)
        else $error("torque shares exceed one");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind limited_slip_torque_split lsts_checker u_lsts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);
`default_nettype wire

### sim/tb_limited_slip_torque_split.sv
module tb_limited_slip_torque_split;
    import lsts_pkg::*;

    localparam int LATENCY = 69;
    localparam int N_RANDOM = 1330;

    class share_scoreboard;
        t_out_word expected_q[$];
        int mismatches;
        int checked;
        logic [16:0] split;
        logic enable;
        logic [30:0] ratio;

        function void reset_regs();
            split = 17'd32768;
            enable = 1'b1;
            ratio = 31'd91750;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [30:0] value);
            case (idx)
                CFG_SPLIT: split = value[16:0];
                CFG_ENABLE: enable = value[0];
                CFG_RATIO: ratio = value;
                default: ;
            endcase
        endfunction

        function logic [63:0] mag(logic [31:0] raw);
            if (raw[31]) return 64'h1_0000_0000 - {32'd0, raw};
            return {32'd0, raw};
        endfunction

        function void note_input(t_in_word w);
            logic [63:0] sp, lft, rgt, wl, wr, lo, hi, q, den, alpha, oma;
            t_out_word r;
            sp = (split > 17'd65536) ? 64'd65536 : {47'd0, split};
            lft = 64'd65536 - sp;
            rgt = sp;
            if (enable) begin
                wl = mag(w.left_speed);
                wr = mag(w.right_speed);
                if (wl < 64'd66) wl = 64'd66;
                if (wr < 64'd66) wr = 64'd66;
                lo = (wl < wr) ? wl : wr;
                hi = (wl < wr) ? wr : wl;
                q = (hi << 16) / lo;
                den = (ratio > 31'd65536) ? {33'd0, ratio} - 64'd65536 : 64'd1;
                alpha = ((q - 64'd65536) << 16) / den;
                if (alpha > 64'd65536) alpha = 64'd65536;
                oma = 64'd65536 - alpha;
                lft = (lft * oma) >> 16;
                rgt = (rgt * oma) >> 16;
                if (wl < wr) lft += alpha;
                else rgt += alpha;
            end
            r.left_share = lft[16:0];
            r.right_share = rgt[16:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word e;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.left_share !== e.left_share || got.right_share !== e.right_share) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp L=%0d R=%0d got L=%0d R=%0d",
                             e.left_share, e.right_share, got.left_share, got.right_share);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_in_valid, i_out_stall, i_cfg_we;
    logic o_in_stall, o_out_valid;
    t_in_word i_in_data;
    t_out_word o_out_data;
    logic [1:0] i_cfg_idx;
    logic [30:0] i_cfg_data;

    share_scoreboard sb;
    int hold_cycles;
    bit stall_random;
    int settings_used;

    limited_slip_torque_split uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAIL limited_slip_torque_split");
        $finish;
    end

    // receiver: checks at the edge, then picks the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_stall <= 1'b1;
            end else if (stall_random) begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(t_in_word w);
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
    endtask

    task automatic send_gap();
        int g;
        i_in_valid <= 1'b0;
        g = $urandom_range(1, 6);
        repeat (g) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // caller idles the input first and drops the write enable afterwards
    task automatic write_cfg(t_cfg_idx idx, logic [30:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    function automatic logic [31:0] rand_speed();
        logic [31:0] base, v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 200);
            2: v = 32'h8000_0000 + $urandom_range(0, 3);
            3: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: begin
                base = $urandom_range(65536, 65536 * 200);
                v = base;
            end
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w.left_speed = rand_speed();
        case ($urandom_range(0, 4))
            0: w.right_speed = w.left_speed;
            1: w.right_speed = -w.left_speed;
            2: w.right_speed = w.left_speed + $signed($urandom_range(0, 40000)) - 20000;
            default: w.right_speed = rand_speed();
        endcase
        return w;
    endfunction

    task automatic apply_setting(logic [16:0] s, logic en, logic [30:0] r);
        drain();
        write_cfg(CFG_SPLIT, {14'd0, s});
        write_cfg(CFG_ENABLE, {30'd0, en});
        write_cfg(CFG_RATIO, r);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        t_in_word w;
        int sent, burst;
        logic [30:0] ratio_pick;
        sb = new();
        sb.reset_regs();
        hold_cycles = 0;
        stall_random = 0;
        settings_used = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_SPLIT;
        i_cfg_data = '0;
        i_in_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, zero speeds, extremes, ties, open split
        w.left_speed = 0; w.right_speed = 0; send_word(w);
        w.left_speed = 32'sh8000_0000; w.right_speed = 32'sh7FFF_FFFF; send_word(w);
        w.left_speed = 32'sh7FFF_FFFF; w.right_speed = 32'sh8000_0000; send_word(w);
        w.left_speed = 32'sh8000_0000; w.right_speed = 32'sh8000_0000; send_word(w);
        w.left_speed = 65536; w.right_speed = -65536; send_word(w);
        w.left_speed = 65536; w.right_speed = 80000; send_word(w);
        w.left_speed = 100000; w.right_speed = 65536; send_word(w);
        w.left_speed = 65; w.right_speed = 66; send_word(w);
        w.left_speed = -1; w.right_speed = 67; send_word(w);
        w.left_speed = 32'shFFFF_FFFF; w.right_speed = 32'sh5555_AAAA; send_word(w);
        apply_setting(17'd131071, 1'b1, 31'd65536);
        w.left_speed = 65536; w.right_speed = 65536; send_word(w);
        w.left_speed = 65536; w.right_speed = 65537; send_word(w);
        w.left_speed = 70000; w.right_speed = 65536; send_word(w);
        apply_setting(17'd0, 1'b1, 31'h7FFF_FFFF);
        w.left_speed = 32'sh8000_0000; w.right_speed = 66; send_word(w);
        w.left_speed = 1000; w.right_speed = 2000; send_word(w);
        apply_setting(17'd65536, 1'b0, 31'd0);
        w.left_speed = 12345; w.right_speed = -99999; send_word(w);
        apply_setting(17'd65537, 1'b0, 31'd65537);
        w.left_speed = 0; w.right_speed = 0; send_word(w);
        apply_setting(17'd40000, 1'b1, 31'd65537);
        w.left_speed = 65536; w.right_speed = 65537; send_word(w);
        w.left_speed = 65538; w.right_speed = 65536; send_word(w);

        stall_random = 1;
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent % 200 == 0) begin
                case ($urandom_range(0, 3))
                    0: ratio_pick = $urandom_range(0, 65536);
                    1: ratio_pick = $urandom_range(65537, 200000);
                    2: ratio_pick = $urandom() >> 1;
                    default: ratio_pick = 31'h7FFF_FFFF;
                endcase
                apply_setting($urandom_range(0, 131071), ($urandom_range(0, 4) != 0),
                              ratio_pick);
            end
            if (sent == 600) hold_cycles = 300;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                send_word(rand_word());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) send_gap();
        end
        drain();

        $display("covered %0d checked words over %0d register settings", sb.checked,
                 settings_used + 1);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS limited_slip_torque_split");
        end else begin
            $display("mismatches: %0d", sb.mismatches);
            $display("FAIL limited_slip_torque_split");
        end
        $finish;
    end

endmodule
